FILE: hw/rtl/smbpn_pkg.sv
// package for the stereo mix bus peak normalizer
// types, codes, widths and helper functions shared by every block but the ram and the checker
// no dependencies
`default_nettype none

package smbpn_pkg;

  localparam int unsigned FRAMES    = 65536;
  localparam int unsigned ADDR_W    = $clog2(FRAMES);
  localparam int unsigned TIME_W    = 20;
  localparam int unsigned OFF_W     = 16;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned PROD_W    = 29;
  localparam int unsigned QUOT_W    = 26;
  localparam int unsigned FULL_W    = 27;
  localparam int unsigned RECIP_W   = 32;
  localparam int unsigned RECIP_SH  = 35;
  localparam int unsigned QBITS     = 15;
  localparam int unsigned ENTRY_W   = 2 * SUM_W;

  localparam logic [8:0]          MS_TO_FRAMES = 9'd441;
  localparam logic [RECIP_W-1:0]  RECIP_10     = 32'hCCCC_CCCD;
  localparam logic [FULL_W-1:0]   FRAMES_FULL  = FULL_W'(FRAMES);
  localparam logic [ADDR_W-1:0]   LAST_ADDR    = ADDR_W'(FRAMES - 1);
  localparam logic [SUM_W-1:0]    UNITY_PEAK   = 32'd32768;

  typedef enum logic [1:0] {
    OP_MIX     = 2'd0,
    OP_MEASURE = 2'd1,
    OP_EMIT    = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  typedef struct packed {
    op_e                         op;
    logic [ADDR_W-1:0]           addr;
    logic                        oob;
    logic signed [SAMPLE_W-1:0]  left;
    logic signed [SAMPLE_W-1:0]  right;
  } cmd_t;

  function automatic logic [SUM_W-1:0] mag32(input logic [SUM_W-1:0] v);
    mag32 = v[SUM_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [SAMPLE_W-1:0] sat16(input logic neg, input logic [SUM_W-1:0] q);
    logic [SUM_W-1:0] nq;
    nq = ~q + 1'b1;
    if (neg) begin
      sat16 = (q >= UNITY_PEAK) ? 16'h8000 : nq[SAMPLE_W-1:0];
    end else begin
      sat16 = (q > 32'd32767) ? 16'h7FFF : q[SAMPLE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/smbpn_if.sv
// valid/ready channel interfaces for input and result items
// depends on smbpn_pkg
`default_nettype none

interface smbpn_in_if;
  logic                                      valid;
  logic                                      ready;
  logic [1:0]                                op;
  logic [smbpn_pkg::TIME_W-1:0]              time_ms;
  logic [smbpn_pkg::OFF_W-1:0]               sample_offset;
  logic signed [smbpn_pkg::SAMPLE_W-1:0]     left_in;
  logic signed [smbpn_pkg::SAMPLE_W-1:0]     right_in;
  modport source (output valid, op, time_ms, sample_offset, left_in, right_in, input ready);
  modport sink   (input valid, op, time_ms, sample_offset, left_in, right_in, output ready);
endinterface

interface smbpn_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [smbpn_pkg::SAMPLE_W-1:0]     left_out;
  logic signed [smbpn_pkg::SAMPLE_W-1:0]     right_out;
  logic                                      status;
  modport source (output valid, left_out, right_out, status, input ready);
  modport sink   (input valid, left_out, right_out, status, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/stereo_mix_bus_peak_normalizer.sv
// states: front idle, multiply, divide and push; back idle and out for restart
// or a flagged item, idle, execute and out otherwise, and divide before out for an emit when
// peak exceeds 32768 (15 step restoring divider); the front takes one item at a time
// front and back overlap through a two entry queue; a result register frees the back end
// after reset the frame store is cleared one entry a cycle, all FRAMES entries, before items flow
// items are accepted during the clearing pass and wait in the queue
// top level: front end, command queue and back end with frame store
`default_nettype none

module stereo_mix_bus_peak_normalizer (
  input  wire          clk_i,
  input  wire          rst_ni,
  smbpn_in_if.sink     in_i,
  smbpn_out_if.source  out_o
);

  logic            push, full, pop, empty;
  smbpn_pkg::cmd_t cmd, head;

  smbpn_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .cmd_o  (cmd),
    .full_i (full)
  );

  smbpn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  smbpn_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/smbpn_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module smbpn_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 65536
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/smbpn_front.sv
// front end: accepts items and converts time and offset to a frame address
// depends on smbpn_pkg and smbpn_if
`default_nettype none

module smbpn_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  smbpn_in_if.sink             in_i,
  output logic                 push_o,
  output smbpn_pkg::cmd_t      cmd_o,
  input  wire                  full_i
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0] state_q, state_d;
  logic [1:0]                           op_q;
  logic [smbpn_pkg::TIME_W-1:0]         time_q;
  logic [smbpn_pkg::OFF_W-1:0]          off_q;
  logic signed [smbpn_pkg::SAMPLE_W-1:0] left_q, right_q;
  logic [smbpn_pkg::PROD_W-1:0]         prod_q;
  logic [smbpn_pkg::QUOT_W-1:0]         quot_q;
  logic [smbpn_pkg::PROD_W+smbpn_pkg::RECIP_W-1:0] recip_prod;
  logic [smbpn_pkg::FULL_W-1:0]         full_addr;

  assign in_i.ready = (state_q == F_IDLE);
  assign recip_prod = (smbpn_pkg::PROD_W+smbpn_pkg::RECIP_W)'(prod_q) *
                      (smbpn_pkg::PROD_W+smbpn_pkg::RECIP_W)'(smbpn_pkg::RECIP_10);
  assign full_addr  = smbpn_pkg::FULL_W'(quot_q) + smbpn_pkg::FULL_W'(off_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (in_i.valid) state_d = F_MUL;
      F_MUL:  state_d = F_DIV;
      F_DIV:  state_d = F_PUSH;
      F_PUSH: if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign cmd_o.op   = smbpn_pkg::op_e'(op_q);
  assign cmd_o.addr = full_addr[smbpn_pkg::ADDR_W-1:0];
  assign cmd_o.oob  = (op_q != smbpn_pkg::OP_RESTART) && (full_addr >= smbpn_pkg::FRAMES_FULL);
  assign cmd_o.left  = left_q;
  assign cmd_o.right = right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q    <= in_i.op;
      time_q  <= in_i.time_ms;
      off_q   <= in_i.sample_offset;
      left_q  <= in_i.left_in;
      right_q <= in_i.right_in;
    end
    if (state_q == F_MUL) begin
      prod_q <= smbpn_pkg::PROD_W'(time_q) * smbpn_pkg::PROD_W'(smbpn_pkg::MS_TO_FRAMES);
    end
    if (state_q == F_DIV) begin
      quot_q <= recip_prod[smbpn_pkg::RECIP_SH +: smbpn_pkg::QUOT_W];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/smbpn_queue.sv
// two entry command queue between front and back end
// depends on smbpn_pkg
`default_nettype none

module smbpn_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  smbpn_pkg::cmd_t      cmd_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output logic                 empty_o,
  output smbpn_pkg::cmd_t      head_o
);

  smbpn_pkg::cmd_t slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= cmd_i;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/smbpn_back.sv
// back end: clears the frame store, runs mix, measure, emit and restart
// depends on smbpn_pkg, smbpn_if and smbpn_ram
`default_nettype none

module smbpn_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  empty_i,
  input  smbpn_pkg::cmd_t      head_i,
  output logic                 pop_o,
  smbpn_out_if.source          out_o
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EX   = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam int unsigned SW = smbpn_pkg::SUM_W;

  logic [2:0]                     state_q;
  logic [smbpn_pkg::ADDR_W-1:0]   clr_q;
  smbpn_pkg::cmd_t                cmd_q;
  logic [SW-1:0]                  peak_q;
  logic [SW-1:0]                  ql_q, qr_q, reml_q, remr_q;
  logic                           negl_q, negr_q, satl_q, satr_q, status_q;
  logic [3:0]                     step_q;
  logic                           ovalid_q;
  logic [smbpn_pkg::SAMPLE_W-1:0] oleft_q, oright_q;
  logic                           ostatus_q;

  logic                           we;
  logic [smbpn_pkg::ADDR_W-1:0]   waddr;
  logic [smbpn_pkg::ENTRY_W-1:0]  wdata, rdata;
  logic [SW-1:0]                  suml, sumr, magl, magr, mixl, mixr, pk1;
  logic [SW:0]                    shl, shr;
  logic                           gel, ger;

  smbpn_ram #(.WIDTH(smbpn_pkg::ENTRY_W), .DEPTH(smbpn_pkg::FRAMES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (head_i.addr),
    .rdata_o (rdata)
  );

  assign suml = rdata[SW-1:0];
  assign sumr = rdata[2*SW-1:SW];
  assign magl = smbpn_pkg::mag32(suml);
  assign magr = smbpn_pkg::mag32(sumr);
  assign mixl = suml + {{(SW-smbpn_pkg::SAMPLE_W){cmd_q.left[15]}}, cmd_q.left};
  assign mixr = sumr + {{(SW-smbpn_pkg::SAMPLE_W){cmd_q.right[15]}}, cmd_q.right};
  assign pk1  = (magl > peak_q) ? magl : peak_q;
  assign shl  = {reml_q, 1'b0};
  assign shr  = {remr_q, 1'b0};
  assign gel  = shl >= {1'b0, peak_q};
  assign ger  = shr >= {1'b0, peak_q};

  assign pop_o = (state_q == S_IDLE) && !empty_i;

  always_comb begin
    we    = 1'b0;
    waddr = cmd_q.addr;
    wdata = '0;
    if (state_q == S_CLR) begin
      we    = 1'b1;
      waddr = clr_q;
    end else if (state_q == S_EX && cmd_q.op == smbpn_pkg::OP_MIX) begin
      we    = 1'b1;
      wdata = {mixr, mixl};
    end else if (state_q == S_EX && cmd_q.op == smbpn_pkg::OP_EMIT) begin
      we    = 1'b1;
    end
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.left_out  = oleft_q;
  assign out_o.right_out = oright_q;
  assign out_o.status    = ostatus_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      peak_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (ovalid_q && out_o.ready) ovalid_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == smbpn_pkg::LAST_ADDR) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (!empty_i) begin
            if (head_i.op == smbpn_pkg::OP_RESTART) begin
              peak_q  <= '0;
              state_q <= S_OUT;
            end else if (head_i.oob) begin
              state_q <= S_OUT;
            end else begin
              state_q <= S_EX;
            end
          end
        end
        S_EX: begin
          if (cmd_q.op == smbpn_pkg::OP_MEASURE) begin
            peak_q <= (magr > pk1) ? magr : pk1;
          end
          if (cmd_q.op == smbpn_pkg::OP_EMIT && peak_q > smbpn_pkg::UNITY_PEAK) begin
            state_q <= S_DIV;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_DIV: begin
          if (step_q == 4'(smbpn_pkg::QBITS - 1)) state_q <= S_OUT;
        end
        S_OUT: begin
          if (!ovalid_q) begin
            ovalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cmd_q    <= head_i;
        status_q <= head_i.oob;
        ql_q     <= '0;
        qr_q     <= '0;
        negl_q   <= 1'b0;
        negr_q   <= 1'b0;
      end
      S_EX: begin
        step_q <= '0;
        satl_q <= magl >= peak_q;
        satr_q <= magr >= peak_q;
        reml_q <= magl;
        remr_q <= magr;
        if (cmd_q.op == smbpn_pkg::OP_EMIT) begin
          negl_q <= suml[SW-1];
          negr_q <= sumr[SW-1];
          ql_q   <= (peak_q > smbpn_pkg::UNITY_PEAK) ? '0 : magl;
          qr_q   <= (peak_q > smbpn_pkg::UNITY_PEAK) ? '0 : magr;
        end
      end
      S_DIV: begin
        step_q <= step_q + 4'd1;
        reml_q <= gel ? SW'(shl - {1'b0, peak_q}) : shl[SW-1:0];
        remr_q <= ger ? SW'(shr - {1'b0, peak_q}) : shr[SW-1:0];
        if (step_q == 4'(smbpn_pkg::QBITS - 1)) begin
          ql_q <= satl_q ? smbpn_pkg::UNITY_PEAK : {ql_q[SW-2:0], gel};
          qr_q <= satr_q ? smbpn_pkg::UNITY_PEAK : {qr_q[SW-2:0], ger};
        end else begin
          ql_q <= {ql_q[SW-2:0], gel};
          qr_q <= {qr_q[SW-2:0], ger};
        end
      end
      S_OUT: begin
        if (!ovalid_q) begin
          oleft_q   <= smbpn_pkg::sat16(negl_q, ql_q);
          oright_q  <= smbpn_pkg::sat16(negr_q, qr_q);
          ostatus_q <= status_q;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/smbpn_checker.sv
// port level checks for the normalizer, attached by bind
// depends on stereo_mix_bus_peak_normalizer ports only
`default_nettype none

module smbpn_port_checks (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [15:0] left_out_i,
  input wire [15:0] right_out_i,
  input wire        status_i
);

  logic [3:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 4'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 4'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 4'd0) else $error("result without item");

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> left_out_i == 16'd0 && right_out_i == 16'd0)
    else $error("flagged item with samples");

  // front, two queue slots, back end and result register
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 4'd5) else $error("too many items in flight");

endmodule

bind stereo_mix_bus_peak_normalizer smbpn_port_checks u_smbpn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .left_out_i  (out_o.left_out),
  .right_out_i (out_o.right_out),
  .status_i    (out_o.status)
);

`default_nettype wire
